FILE: sv/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and code-layout functions for the Hamming codec.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int CW_BITS   = 71;    // longest codeword (64 data + 7 check)
    localparam int DATA_BITS = 64;
    localparam int SYN_BITS  = 7;
    localparam int IN_BITS   = 72;    // word_low + word_high, byte padded
    localparam int OUT_BITS  = 144;   // all result fields, exactly 18 bytes
    localparam int NUM_CODES = 7;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [2:0] WCODE_MAX = 3'd6;

    typedef logic [CW_BITS-1:0]  t_cw;     // bit p-1 holds position p
    typedef logic [SYN_BITS-1:0] t_syn;

    typedef struct packed {
        logic       mode;
        logic [2:0] wcode;
    } t_ctl;

    typedef struct packed {
        logic corrected;
        logic invalid;
    } t_flags;

    // data bits for a width code
    function automatic int k_of(logic [2:0] code);
        int k;
        unique case (code)
            3'd0:    k = 8;
            3'd1:    k = 12;
            3'd2:    k = 16;
            3'd3:    k = 24;
            3'd4:    k = 32;
            3'd5:    k = 48;
            default: k = 64;
        endcase
        return k;
    endfunction

    // check bits for a width code
    function automatic int r_of(logic [2:0] code);
        int r;
        unique case (code)
            3'd0:                   r = 4;
            3'd1, 3'd2, 3'd3:       r = 5;
            3'd4, 3'd5:             r = 6;
            default:                r = 7;
        endcase
        return r;
    endfunction

    function automatic int n_of(logic [2:0] code);
        return k_of(code) + r_of(code);
    endfunction

    function automatic logic is_pow2(int p);
        return (p & (p - 1)) == 0;
    endfunction

    // 1-based rank of position p among the data (non power of two) positions
    function automatic int pos_ord(int p);
        int cnt;
        cnt = 0;
        for (int d = 0; d < SYN_BITS; d++) begin
            if ((1 << d) <= p) cnt++;
        end
        return p - cnt;
    endfunction

    // codeword position of the j-th data position (1 when out of range)
    function automatic int data_pos(int j);
        int cnt;
        int pos;
        cnt = 0;
        pos = 1;
        for (int p = 1; p <= CW_BITS; p++) begin
            if (!is_pow2(p)) begin
                cnt++;
                if (cnt == j) pos = p;
            end
        end
        return pos;
    endfunction

    // fold unused code 7 to 64 bits, then step down until the data width fits the limit
    function automatic logic [2:0] eff_code(logic [2:0] code, int max_bits);
        logic [2:0] c;
        c = (code > WCODE_MAX) ? WCODE_MAX : code;
        for (int s = 0; s < NUM_CODES - 1; s++) begin
            if (c != 3'd0 && k_of(c) > max_bits) c = c - 3'd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hamming_sec_codec.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec
// Hamming single-error-correcting encoder/decoder, 8 to 64 data bits.
// ----------------------------------------------------------------------------
// Input word: s_axis_tuser selects encode (0) or decode (1). tdata carries
// the data right-aligned (encode) or codeword positions 1..71 (decode).
// Output word: code_low/code_high for encode; corrected data, syndrome and
// flags for decode. Fields of the unused mode read as zero.
// i_cfg_we/i_cfg_wdata set the width code; write it only while idle.
// Four register stages: map, syndrome, correct, gather. Throughput: one word
// per cycle while the receiver keeps m_axis_tready high; each stage holds one
// word, and the syndrome XOR tree over 71 positions sets the stage depth.
// Reset empties all stages and sets the width code to 8 bits.
// When the receiver stalls, full stages hold their words and s_axis_tready
// drops once the pipe backs up to the input; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_codec #(
    parameter int MAX_DATA_BITS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [2:0]                i_cfg_wdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [63:0] word_low, [70:64] word_high, [71] zero
    input  wire logic [hsc_pkg::IN_BITS-1:0]  s_axis_tdata,
    // [0] mode
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [63:0] code_low, [70:64] code_high, [134:71] data_out,
    // [135] error_corrected, [142:136] error_position, [143] syndrome_invalid
    output logic [hsc_pkg::OUT_BITS-1:0]   m_axis_tdata
);
    import hsc_pkg::*;

    logic [2:0] r_width_select;
    t_ctl       in_ctl;

    logic   s1_valid, s1_ready;
    t_ctl   s1_ctl;
    t_cw    s1_cw;
    logic   s2_valid, s2_ready;
    t_ctl   s2_ctl;
    t_cw    s2_cw;
    t_syn   s2_syn;
    logic   s3_valid, s3_ready;
    t_ctl   s3_ctl;
    t_cw    s3_cw;
    t_syn   s3_syn;
    t_flags s3_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_select <= 3'd0;
        end else if (i_cfg_we) begin
            r_width_select <= i_cfg_wdata;
        end
    end

    assign in_ctl.mode  = s_axis_tuser;
    assign in_ctl.wcode = eff_code(r_width_select, MAX_DATA_BITS);

    hsc_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_ctl       (in_ctl),
        .i_word_low  (s_axis_tdata[63:0]),
        .i_word_high (s_axis_tdata[70:64]),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_ctl       (s1_ctl),
        .o_cw        (s1_cw)
    );

    hsc_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_ctl   (s1_ctl),
        .i_cw    (s1_cw),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_ctl   (s2_ctl),
        .o_cw    (s2_cw),
        .o_syn   (s2_syn)
    );

    hsc_correct u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_ctl   (s2_ctl),
        .i_cw    (s2_cw),
        .i_syn   (s2_syn),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_ctl   (s3_ctl),
        .o_cw    (s3_cw),
        .o_syn   (s3_syn),
        .o_flags (s3_flags)
    );

    hsc_gather u_gather (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_ctl   (s3_ctl),
        .i_cw    (s3_cw),
        .i_syn   (s3_syn),
        .i_flags (s3_flags),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: sv/hsc_map.sv
// ----------------------------------------------------------------------------
// hsc_map
// Stage 1: lays the input word out as a codeword. Encode scatters the data
// bits MSB first into the data positions; decode masks positions beyond n.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_map (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire hsc_pkg::t_ctl             i_ctl,
    input  wire logic [63:0]               i_word_low,
    input  wire logic [6:0]                i_word_high,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output hsc_pkg::t_ctl                  o_ctl,
    output hsc_pkg::t_cw                   o_cw
);
    import hsc_pkg::*;

    logic  r_valid;
    t_ctl  r_ctl;
    t_cw   r_cw;
    t_cw   n_cw;
    t_cw   word_all;

    assign word_all = {i_word_high, i_word_low};
    assign o_ready  = !r_valid || i_ready;

    always_comb begin
        logic [6:0] k;
        logic [6:0] n;
        logic [6:0] idx;
        n_cw = '0;
        k    = 7'(k_of(i_ctl.wcode));
        n    = 7'(n_of(i_ctl.wcode));
        for (int p = 1; p <= CW_BITS; p++) begin
            idx = k - 7'(pos_ord(p));
            if (p <= int'(n)) begin
                if (i_ctl.mode == MODE_DEC) begin
                    n_cw[p-1] = word_all[p-1];
                end else if (!is_pow2(p)) begin
                    n_cw[p-1] = i_word_low[idx[5:0]];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_cw  <= n_cw;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_cw    = r_cw;

endmodule

`default_nettype wire

FILE: sv/hsc_syndrome.sv
// ----------------------------------------------------------------------------
// hsc_syndrome
// Stage 2: XOR of the indices of all set codeword positions.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_syndrome (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire hsc_pkg::t_ctl             i_ctl,
    input  wire hsc_pkg::t_cw              i_cw,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output hsc_pkg::t_ctl                  o_ctl,
    output hsc_pkg::t_cw                   o_cw,
    output hsc_pkg::t_syn                  o_syn
);
    import hsc_pkg::*;

    logic  r_valid;
    t_ctl  r_ctl;
    t_cw   r_cw;
    t_syn  r_syn;
    t_syn  n_syn;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_syn = '0;
        for (int p = 1; p <= CW_BITS; p++) begin
            if (i_cw[p-1]) n_syn = n_syn ^ SYN_BITS'(p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_cw  <= i_cw;
            r_syn <= n_syn;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_cw    = r_cw;
    assign o_syn   = r_syn;

endmodule

`default_nettype wire

FILE: sv/hsc_correct.sv
// ----------------------------------------------------------------------------
// hsc_correct
// Stage 3: encode fills the check positions from the syndrome; decode flips
// the addressed position or flags a syndrome beyond the code length.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_correct (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire hsc_pkg::t_ctl             i_ctl,
    input  wire hsc_pkg::t_cw              i_cw,
    input  wire hsc_pkg::t_syn             i_syn,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output hsc_pkg::t_ctl                  o_ctl,
    output hsc_pkg::t_cw                   o_cw,
    output hsc_pkg::t_syn                  o_syn,
    output hsc_pkg::t_flags                o_flags
);
    import hsc_pkg::*;

    logic    r_valid;
    t_ctl    r_ctl;
    t_cw     r_cw;
    t_syn    r_syn;
    t_flags  r_flags;
    t_cw     n_cw;
    t_flags  n_flags;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic [6:0] n;
        logic [2:0] r;
        logic       flip;
        n       = 7'(n_of(i_ctl.wcode));
        r       = 3'(r_of(i_ctl.wcode));
        flip    = (i_syn != '0) && (i_syn <= n);
        n_cw    = i_cw;
        n_flags = '0;
        if (i_ctl.mode == MODE_ENC) begin
            // check positions arrive zero, syndrome covers data only
            for (int d = 0; d < SYN_BITS; d++) begin
                if (d < int'(r)) n_cw[(1 << d) - 1] = i_syn[d];
            end
        end else begin
            for (int p = 1; p <= CW_BITS; p++) begin
                if (flip && i_syn == SYN_BITS'(p)) n_cw[p-1] = ~i_cw[p-1];
            end
            n_flags.corrected = flip;
            n_flags.invalid   = (i_syn > n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl   <= i_ctl;
            r_cw    <= n_cw;
            r_syn   <= i_syn;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_cw    = r_cw;
    assign o_syn   = r_syn;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: sv/hsc_gather.sv
// ----------------------------------------------------------------------------
// hsc_gather
// Stage 4: strips the check bits on decode and packs the result word into
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_gather (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire hsc_pkg::t_ctl             i_ctl,
    input  wire hsc_pkg::t_cw              i_cw,
    input  wire hsc_pkg::t_syn             i_syn,
    input  wire hsc_pkg::t_flags           i_flags,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [hsc_pkg::OUT_BITS-1:0]   o_data
);
    import hsc_pkg::*;

    logic                   r_valid;
    logic [OUT_BITS-1:0]    r_data;
    logic [OUT_BITS-1:0]    n_data;
    logic [DATA_BITS-1:0]   data;

    assign o_ready = !r_valid || i_ready;

    // data bit i sits at the (k-i)-th data position
    always_comb begin
        data = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            for (int c = 0; c < NUM_CODES; c++) begin
                if (i_ctl.wcode == 3'(c) && i < k_of(3'(c))) begin
                    data[i] = i_cw[data_pos(k_of(3'(c)) - i) - 1];
                end
            end
        end
    end

    always_comb begin
        if (i_ctl.mode == MODE_ENC) begin
            n_data = {1'b0, t_syn'(0), 1'b0, {DATA_BITS{1'b0}}, i_cw};
        end else begin
            n_data = {i_flags.invalid, i_syn, i_flags.corrected, data, t_cw'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
